### hw/rtl/avr_data_memory_gpio_irq_unit_defines.svh
// assertion macros for the data space unit
`ifndef AVR_DATA_MEMORY_GPIO_IRQ_UNIT_DEFINES_SVH
`define AVR_DATA_MEMORY_GPIO_IRQ_UNIT_DEFINES_SVH

// same-cycle implication, checked on clk, off while rst_n is low
`define AVRDM_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk, off while rst_n is low
`define AVRDM_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/avrdm_pkg.sv
// types, register addresses and reset values of the data space unit
package avrdm_pkg;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_POLL  = 2'd2,
        CMD_PIN   = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        SEL_PINB,
        SEL_DDRB,
        SEL_PORTB,
        SEL_PINC,
        SEL_DDRC,
        SEL_PORTC,
        SEL_PIND,
        SEL_DDRD,
        SEL_PORTD,
        SEL_EIFR,
        SEL_EIMSK,
        SEL_SREG,
        SEL_EICRA,
        SEL_MEM,
        SEL_NONE
    } reg_sel_t;

    localparam logic [7:0] A_PINB   = 8'h23;
    localparam logic [7:0] A_DDRB   = 8'h24;
    localparam logic [7:0] A_PORTB  = 8'h25;
    localparam logic [7:0] A_PINC   = 8'h26;
    localparam logic [7:0] A_DDRC   = 8'h27;
    localparam logic [7:0] A_PORTC  = 8'h28;
    localparam logic [7:0] A_PIND   = 8'h29;
    localparam logic [7:0] A_DDRD   = 8'h2A;
    localparam logic [7:0] A_PORTD  = 8'h2B;
    localparam logic [7:0] A_EIFR   = 8'h3C;
    localparam logic [7:0] A_EIMSK  = 8'h3D;
    localparam logic [7:0] A_SPL    = 8'h5D;
    localparam logic [7:0] A_SPH    = 8'h5E;
    localparam logic [7:0] A_SREG   = 8'h5F;
    localparam logic [7:0] A_OSCCAL = 8'h66;
    localparam logic [7:0] A_EICRA  = 8'h69;
    localparam logic [7:0] A_TWSR   = 8'hB9;
    localparam logic [7:0] A_TWAR   = 8'hBA;
    localparam logic [7:0] A_TWDR   = 8'hBB;
    localparam logic [7:0] A_UCSR0A = 8'hC0;
    localparam logic [7:0] A_UCSR0C = 8'hC2;

    localparam logic [15:0] TOP_OF_RAM = 16'h08FF;

    localparam logic [2:0] VEC_NONE = 3'd0;
    localparam logic [2:0] VEC_INT0 = 3'd2;
    localparam logic [2:0] VEC_INT1 = 3'd4;

    localparam logic [4:0] PIN_B_BASE = 5'd8;
    localparam logic [4:0] PIN_C_BASE = 5'd14;
    localparam logic [4:0] PIN_END    = 5'd20;

    function automatic logic [7:0] init_byte(input logic [15:0] a);
        logic [7:0] v;
        v = 8'h00;
        case (a)
            16'(A_UCSR0C): v = 8'h06;
            16'(A_UCSR0A): v = 8'h40;
            16'(A_TWDR):   v = 8'hFF;
            16'(A_TWAR):   v = 8'hFE;
            16'(A_TWSR):   v = 8'hF8;
            16'(A_OSCCAL): v = 8'h9F;
            16'(A_SPH):    v = TOP_OF_RAM[15:8];
            16'(A_SPL):    v = TOP_OF_RAM[7:0];
            default:       v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/avrdm_if.sv
// request and response channel interfaces of the data space unit
interface avrdm_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [11:0] addr;
    logic [7:0] wdata;
    logic [4:0] pin_number;
    logic       pin_level;

    modport source (output valid, cmd, addr, wdata, pin_number, pin_level, input ready);
    modport sink   (input valid, cmd, addr, wdata, pin_number, pin_level, output ready);
endinterface

interface avrdm_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] rdata;
    logic       irq_taken;
    logic [2:0] irq_vector;
    logic       port_update;
    logic [7:0] port_reg_addr;
    logic [7:0] port_reg_value;

    modport source (output valid, rdata, irq_taken, irq_vector, port_update, port_reg_addr,
                    port_reg_value, input ready);
    modport sink   (input valid, rdata, irq_taken, irq_vector, port_update, port_reg_addr,
                    port_reg_value, output ready);
endinterface

### hw/rtl/avr_data_memory_gpio_irq_unit.sv
// byte-wide data space with gpio port registers and external interrupt poll
//
// req carries one item: read, write, interrupt poll or input pin drive.
// rsp returns exactly one result item for every accepted item, in order.
// latency: the result is valid in the cycle after the item is accepted.
// throughput: one item per cycle while req.ready is high; the data space
// memory has one write and one registered read port, and every item
// touches it at most once. port, ddr, pin, eifr, eimsk, sreg and eicra
// live in flip-flops so that poll, toggle and compare logic sees them in
// the same cycle. after reset a clearing pass writes the reset image into
// all MEM_DEPTH bytes of the memory, one byte per cycle; req.ready stays
// low meanwhile. the flip-flop registers are cleared at once by reset.
// a single result register sits between req and rsp: when rsp stalls with
// a result held, req.ready drops until that result is taken; when the
// result is taken in the same cycle a new item is accepted.
`include "avr_data_memory_gpio_irq_unit_defines.svh"

module avr_data_memory_gpio_irq_unit #(
    parameter int MEM_DEPTH = 2304
) (
    input  logic             clk,
    input  logic             rst_n,
    avrdm_req_if.sink        req,
    avrdm_rsp_if.source      rsp
);

    localparam int          IDX_W   = $clog2(MEM_DEPTH);
    localparam logic [31:0] DEPTH_U = 32'(MEM_DEPTH);

    logic [7:0] mem [MEM_DEPTH];

    logic             clr_busy_reg;
    logic [IDX_W-1:0] clr_cnt_reg;

    logic [7:0] pinb_reg, ddrb_reg, portb_reg;
    logic [7:0] pinc_reg, ddrc_reg, portc_reg;
    logic [7:0] pind_reg, ddrd_reg, portd_reg;
    logic [7:0] eifr_reg, eimsk_reg, sreg_reg, eicra_reg;
    logic [7:0] pinb_next, ddrb_next, portb_next;
    logic [7:0] pinc_next, ddrc_next, portc_next;
    logic [7:0] pind_next, ddrd_next, portd_next;
    logic [7:0] eifr_next, eimsk_next, sreg_next, eicra_next;

    logic       out_valid_reg;
    logic [7:0] mem_q_reg;
    logic       use_mem_reg, use_mem_next;
    logic [7:0] rd_fast_reg, rd_fast_next;
    logic       taken_reg, taken_next;
    logic [2:0] vec_reg, vec_next;
    logic       upd_reg, upd_next;
    logic [7:0] raddr_reg, raddr_next;
    logic [7:0] rval_reg, rval_next;

    logic                in_acc;
    avrdm_pkg::cmd_t     cmd;
    avrdm_pkg::reg_sel_t sel;
    logic                in_range;
    logic [IDX_W-1:0]    mem_idx;
    logic [7:0]          cur_byte;
    logic                chg;

    logic             mem_we;
    logic             mem_re;
    logic [IDX_W-1:0] mem_waddr;
    logic [7:0]       mem_wdata;

    logic       int0_en, int0_by_flag, int0_by_lvl, int0_lvl, take0;
    logic       int1_en, int1_by_flag, int1_by_lvl, int1_lvl, take1;
    logic [4:0] pin_off;
    logic [7:0] pin_mask;

    assign req.ready = !clr_busy_reg && (!out_valid_reg || rsp.ready);
    assign in_acc    = req.valid && req.ready;
    assign cmd       = avrdm_pkg::cmd_t'(req.cmd);
    assign in_range  = 32'(req.addr) < DEPTH_U;
    assign mem_idx   = IDX_W'(req.addr);

    // address decode
    always_comb
    begin
        case (req.addr)
            12'(avrdm_pkg::A_PINB):  sel = avrdm_pkg::SEL_PINB;
            12'(avrdm_pkg::A_DDRB):  sel = avrdm_pkg::SEL_DDRB;
            12'(avrdm_pkg::A_PORTB): sel = avrdm_pkg::SEL_PORTB;
            12'(avrdm_pkg::A_PINC):  sel = avrdm_pkg::SEL_PINC;
            12'(avrdm_pkg::A_DDRC):  sel = avrdm_pkg::SEL_DDRC;
            12'(avrdm_pkg::A_PORTC): sel = avrdm_pkg::SEL_PORTC;
            12'(avrdm_pkg::A_PIND):  sel = avrdm_pkg::SEL_PIND;
            12'(avrdm_pkg::A_DDRD):  sel = avrdm_pkg::SEL_DDRD;
            12'(avrdm_pkg::A_PORTD): sel = avrdm_pkg::SEL_PORTD;
            12'(avrdm_pkg::A_EIFR):  sel = avrdm_pkg::SEL_EIFR;
            12'(avrdm_pkg::A_EIMSK): sel = avrdm_pkg::SEL_EIMSK;
            12'(avrdm_pkg::A_SREG):  sel = avrdm_pkg::SEL_SREG;
            12'(avrdm_pkg::A_EICRA): sel = avrdm_pkg::SEL_EICRA;
            default:                 sel = in_range ? avrdm_pkg::SEL_MEM
                                                    : avrdm_pkg::SEL_NONE;
        endcase
    end

    always_comb
    begin
        case (sel)
            avrdm_pkg::SEL_PINB:  cur_byte = pinb_reg;
            avrdm_pkg::SEL_DDRB:  cur_byte = ddrb_reg;
            avrdm_pkg::SEL_PORTB: cur_byte = portb_reg;
            avrdm_pkg::SEL_PINC:  cur_byte = pinc_reg;
            avrdm_pkg::SEL_DDRC:  cur_byte = ddrc_reg;
            avrdm_pkg::SEL_PORTC: cur_byte = portc_reg;
            avrdm_pkg::SEL_PIND:  cur_byte = pind_reg;
            avrdm_pkg::SEL_DDRD:  cur_byte = ddrd_reg;
            avrdm_pkg::SEL_PORTD: cur_byte = portd_reg;
            avrdm_pkg::SEL_EIFR:  cur_byte = eifr_reg;
            avrdm_pkg::SEL_EIMSK: cur_byte = eimsk_reg;
            avrdm_pkg::SEL_SREG:  cur_byte = sreg_reg;
            avrdm_pkg::SEL_EICRA: cur_byte = eicra_reg;
            default:              cur_byte = 8'h00;
        endcase
    end

    assign chg = cur_byte != req.wdata;

    // external interrupt lines, int0 has priority
    assign int0_en      = sreg_reg[7] && eimsk_reg[0];
    assign int0_lvl     = ddrd_reg[2] ? portd_reg[2] : pind_reg[2];
    assign int0_by_flag = int0_en && eifr_reg[0];
    assign int0_by_lvl  = int0_en && !eifr_reg[0] && (eicra_reg[1:0] == 2'b00) && !int0_lvl;
    assign take0        = int0_by_flag || int0_by_lvl;

    assign int1_en      = sreg_reg[7] && eimsk_reg[1] && !take0;
    assign int1_lvl     = ddrd_reg[3] ? portd_reg[3] : pind_reg[3];
    assign int1_by_flag = int1_en && eifr_reg[1];
    assign int1_by_lvl  = int1_en && !eifr_reg[1] && (eicra_reg[3:2] == 2'b00) && !int1_lvl;
    assign take1        = int1_by_flag || int1_by_lvl;

    // bit position of the driven pin inside its port
    always_comb
    begin
        if (req.pin_number >= avrdm_pkg::PIN_C_BASE)
        begin
            pin_off = req.pin_number - avrdm_pkg::PIN_C_BASE;
        end
        else if (req.pin_number >= avrdm_pkg::PIN_B_BASE)
        begin
            pin_off = req.pin_number - avrdm_pkg::PIN_B_BASE;
        end
        else
        begin
            pin_off = req.pin_number;
        end
    end

    assign pin_mask = 8'h01 << pin_off[2:0];

    always_comb
    begin
        pinb_next  = pinb_reg;
        ddrb_next  = ddrb_reg;
        portb_next = portb_reg;
        pinc_next  = pinc_reg;
        ddrc_next  = ddrc_reg;
        portc_next = portc_reg;
        pind_next  = pind_reg;
        ddrd_next  = ddrd_reg;
        portd_next = portd_reg;
        eifr_next  = eifr_reg;
        eimsk_next = eimsk_reg;
        sreg_next  = sreg_reg;
        eicra_next = eicra_reg;

        use_mem_next = 1'b0;
        rd_fast_next = 8'h00;
        taken_next   = 1'b0;
        vec_next     = avrdm_pkg::VEC_NONE;
        upd_next     = 1'b0;
        raddr_next   = 8'h00;
        rval_next    = 8'h00;
        mem_re       = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = mem_idx;
        mem_wdata    = req.wdata;

        if (clr_busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = avrdm_pkg::init_byte(16'(clr_cnt_reg));
        end
        else if (in_acc)
        begin
            case (cmd)
                avrdm_pkg::CMD_READ:
                begin
                    rd_fast_next = cur_byte;
                    use_mem_next = sel == avrdm_pkg::SEL_MEM;
                    mem_re       = sel == avrdm_pkg::SEL_MEM;
                end
                avrdm_pkg::CMD_WRITE:
                begin
                    case (sel)
                        avrdm_pkg::SEL_DDRB:  if (chg) ddrb_next  = req.wdata;
                        avrdm_pkg::SEL_PORTB: if (chg) portb_next = req.wdata;
                        avrdm_pkg::SEL_DDRC:  if (chg) ddrc_next  = req.wdata;
                        avrdm_pkg::SEL_PORTC: if (chg) portc_next = req.wdata;
                        avrdm_pkg::SEL_DDRD:  if (chg) ddrd_next  = req.wdata;
                        avrdm_pkg::SEL_PORTD: if (chg) portd_next = req.wdata;
                        avrdm_pkg::SEL_PINB:
                        begin
                            portb_next = portb_reg ^ req.wdata;
                            upd_next   = 1'b1;
                            raddr_next = avrdm_pkg::A_PORTB;
                            rval_next  = portb_reg ^ req.wdata;
                        end
                        avrdm_pkg::SEL_PINC:
                        begin
                            portc_next = portc_reg ^ req.wdata;
                            upd_next   = 1'b1;
                            raddr_next = avrdm_pkg::A_PORTC;
                            rval_next  = portc_reg ^ req.wdata;
                        end
                        avrdm_pkg::SEL_PIND:
                        begin
                            portd_next = portd_reg ^ req.wdata;
                            upd_next   = 1'b1;
                            raddr_next = avrdm_pkg::A_PORTD;
                            rval_next  = portd_reg ^ req.wdata;
                        end
                        avrdm_pkg::SEL_EIFR:  eifr_next  = req.wdata;
                        avrdm_pkg::SEL_EIMSK: eimsk_next = req.wdata;
                        avrdm_pkg::SEL_SREG:  sreg_next  = req.wdata;
                        avrdm_pkg::SEL_EICRA: eicra_next = req.wdata;
                        avrdm_pkg::SEL_MEM:   mem_we     = 1'b1;
                        default:              mem_we     = 1'b0;
                    endcase
                    // port and ddr writes report only a real change
                    if (chg && (sel inside {avrdm_pkg::SEL_DDRB, avrdm_pkg::SEL_PORTB,
                                            avrdm_pkg::SEL_DDRC, avrdm_pkg::SEL_PORTC,
                                            avrdm_pkg::SEL_DDRD, avrdm_pkg::SEL_PORTD}))
                    begin
                        upd_next   = 1'b1;
                        raddr_next = req.addr[7:0];
                        rval_next  = req.wdata;
                    end
                end
                avrdm_pkg::CMD_POLL:
                begin
                    if (take0)
                    begin
                        taken_next = 1'b1;
                        vec_next   = avrdm_pkg::VEC_INT0;
                        if (int0_by_flag)
                        begin
                            eifr_next[0] = 1'b0;
                        end
                    end
                    else if (take1)
                    begin
                        taken_next = 1'b1;
                        vec_next   = avrdm_pkg::VEC_INT1;
                        if (int1_by_flag)
                        begin
                            eifr_next[1] = 1'b0;
                        end
                    end
                end
                avrdm_pkg::CMD_PIN:
                begin
                    if (req.pin_number >= avrdm_pkg::PIN_END)
                    begin
                        pind_next = pind_reg;
                    end
                    else if (req.pin_number >= avrdm_pkg::PIN_C_BASE)
                    begin
                        pinc_next = req.pin_level ? (pinc_reg | pin_mask)
                                                  : (pinc_reg & ~pin_mask);
                    end
                    else if (req.pin_number >= avrdm_pkg::PIN_B_BASE)
                    begin
                        pinb_next = req.pin_level ? (pinb_reg | pin_mask)
                                                  : (pinb_reg & ~pin_mask);
                    end
                    else
                    begin
                        pind_next = req.pin_level ? (pind_reg | pin_mask)
                                                  : (pind_reg & ~pin_mask);
                    end
                end
                default:
                begin
                    mem_re = 1'b0;
                end
            endcase
        end
    end

    // data space memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q_reg <= mem[mem_idx];
        end
    end

    // clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_cnt_reg == IDX_W'(MEM_DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pinb_reg      <= 8'h00;
            ddrb_reg      <= 8'h00;
            portb_reg     <= 8'h00;
            pinc_reg      <= 8'h00;
            ddrc_reg      <= 8'h00;
            portc_reg     <= 8'h00;
            pind_reg      <= 8'h00;
            ddrd_reg      <= 8'h00;
            portd_reg     <= 8'h00;
            eifr_reg      <= 8'h00;
            eimsk_reg     <= 8'h00;
            sreg_reg      <= 8'h00;
            eicra_reg     <= 8'h00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pinb_reg  <= pinb_next;
            ddrb_reg  <= ddrb_next;
            portb_reg <= portb_next;
            pinc_reg  <= pinc_next;
            ddrc_reg  <= ddrc_next;
            portc_reg <= portc_next;
            pind_reg  <= pind_next;
            ddrd_reg  <= ddrd_next;
            portd_reg <= portd_next;
            eifr_reg  <= eifr_next;
            eimsk_reg <= eimsk_next;
            sreg_reg  <= sreg_next;
            eicra_reg <= eicra_next;
            if (in_acc)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            use_mem_reg <= use_mem_next;
            rd_fast_reg <= rd_fast_next;
            taken_reg   <= taken_next;
            vec_reg     <= vec_next;
            upd_reg     <= upd_next;
            raddr_reg   <= raddr_next;
            rval_reg    <= rval_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.rdata          = use_mem_reg ? mem_q_reg : rd_fast_reg;
    assign rsp.irq_taken      = taken_reg;
    assign rsp.irq_vector     = vec_reg;
    assign rsp.port_update    = upd_reg;
    assign rsp.port_reg_addr  = raddr_reg;
    assign rsp.port_reg_value = rval_reg;

    `AVRDM_ASSERT_IMP(a_no_accept_in_clear, clr_busy_reg, !req.ready,
                      "item accepted during clearing pass")
    `AVRDM_ASSERT_IMP(a_irq_vector_match, rsp.valid,
                      rsp.irq_taken == (rsp.irq_vector != avrdm_pkg::VEC_NONE),
                      "irq_taken and irq_vector disagree")
    `AVRDM_ASSERT_IMP(a_update_addr, rsp.valid && rsp.port_update,
                      (rsp.port_reg_addr == avrdm_pkg::A_DDRB)
                      || (rsp.port_reg_addr == avrdm_pkg::A_PORTB)
                      || (rsp.port_reg_addr == avrdm_pkg::A_DDRC)
                      || (rsp.port_reg_addr == avrdm_pkg::A_PORTC)
                      || (rsp.port_reg_addr == avrdm_pkg::A_DDRD)
                      || (rsp.port_reg_addr == avrdm_pkg::A_PORTD),
                      "port update names a register that is not port or ddr")
    `AVRDM_ASSERT_IMP(a_no_update_zero, rsp.valid && !rsp.port_update,
                      (rsp.port_reg_addr == 8'h00) && (rsp.port_reg_value == 8'h00),
                      "port fields not zero without update")
    `AVRDM_ASSERT_NXT(a_int0_flag_ack, in_acc && (cmd == avrdm_pkg::CMD_POLL) && int0_by_flag,
                      !eifr_reg[0],
                      "int0 flag not cleared by acknowledge")

endmodule
